// ----- hdl/psg_pkg.sv -----
package psg_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_TONE_A    = 3'd0;
  localparam logic [2:0] REG_TONE_B    = 3'd1;
  localparam logic [2:0] REG_TONE_C    = 3'd2;
  localparam logic [2:0] REG_NOISE     = 3'd3;
  localparam logic [2:0] REG_ENVELOPE  = 3'd4;
  localparam logic [2:0] REG_MIXER     = 3'd5;
  localparam logic [2:0] REG_FIXED     = 3'd6;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned LEVEL_W  = 5;
  localparam int unsigned NOISE_W  = 17;

  localparam logic [NOISE_W-1:0] NOISE_TAPS  = 17'h14000;
  localparam logic [NOISE_W-1:0] NOISE_SEED  = 17'h00001;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 5'd31;
  localparam logic [8:0]         MIXER_RESET = 9'd219;

  // Item codes
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  typedef enum logic [1:0] {
    PH_STILL = 2'd0,
    PH_FALL  = 2'd1,
    PH_RISE  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    phase_t             phase;
  } env_t;

  // Period counter results: step due before the sample, step due after the
  // advance, count with no advance and count after the advance
  typedef struct packed {
    logic                pre;
    logic                post;
    logic [PERIOD_W-1:0] cnt_hold;
    logic [PERIOD_W-1:0] cnt_run;
  } cnt_res_t;

  // One noise shift
  function automatic logic [NOISE_W-1:0] noise_shift_once(input logic [NOISE_W-1:0] s);
    noise_shift_once = (s >> 1) ^ (s[0] ? NOISE_TAPS : '0);
  endfunction

  // One envelope level step, with the shape deciding what happens at the ends
  function automatic env_t env_step(input env_t st, input logic [3:0] kind);
    env_t r;
    r = st;
    unique case (st.phase)
      PH_FALL: begin
        if (st.level != '0) begin
          r.level = st.level - 1'b1;
        end else begin
          unique case (kind)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd9: r.phase = PH_STILL;
            4'd8:                          r.level = LEVEL_MAX;
            4'd10, 4'd14:                  r.phase = PH_RISE;
            4'd11: begin
              r.level = LEVEL_MAX;
              r.phase = PH_STILL;
            end
            default: ;
          endcase
        end
      end
      PH_RISE: begin
        if (st.level != LEVEL_MAX) begin
          r.level = st.level + 1'b1;
        end else begin
          unique case (kind)
            4'd4, 4'd5, 4'd6, 4'd7, 4'd15: begin
              r.level = '0;
              r.phase = PH_STILL;
            end
            4'd10, 4'd14: r.phase = PH_FALL;
            4'd12:        r.level = '0;
            4'd13:        r.phase = PH_STILL;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    env_step = r;
  endfunction

endpackage

// ----- hdl/psg_tone_noise_envelope_synth_core.sv -----
// Channel   Direction  Handshake              Word
// in        sink       in_valid / in_ready    func, envelope_shape
// out       source     out_valid / out_ready  gate_a..c, level_a..c
// cfg       sink       cfg_we                 cfg_index, cfg_data
//
// One word is taken per cycle while the entry register can advance. A tick is
// registered on entry; when it advances it updates all generators and loads
// its result into the result register. A restart gives no result and never waits.
// The result register holds a stalled result; the entry register keeps
// filling until a tick reaches a full, stalled result register.
// Synchronous reset clears the generators, seeds the noise register and loads the register defaults.
module psg_tone_noise_envelope_synth_core
  import psg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic [3:0]          envelope_shape,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                gate_a,
  output logic                gate_b,
  output logic                gate_c,
  output logic [LEVEL_W-1:0]  level_a,
  output logic [LEVEL_W-1:0]  level_b,
  output logic [LEVEL_W-1:0]  level_c,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [PERIOD_W-1:0] cfg_data
);

  // Configuration registers
  logic [PERIOD_W-1:0] tone_period [3];
  logic [PERIOD_W-1:0] noise_period;
  logic [PERIOD_W-1:0] envelope_period;
  logic [8:0]          mixer_enables;
  logic [14:0]         fixed_levels;

  // Generator state
  logic [PERIOD_W-1:0] tone_cnt [3];
  logic [2:0]          tone_bit;
  logic [PERIOD_W-1:0] noise_cnt;
  logic [NOISE_W-1:0]  noise_shift;
  logic [PERIOD_W-1:0] env_cnt;
  env_t                env_st;
  logic [3:0]          env_kind;

  // Entry register
  logic       s1_valid;
  logic       s1_func;
  logic [3:0] s1_shape;
  logic       s1_adv;
  logic       out_free;
  logic       s1_tick;
  logic       s1_restart;

  // Next values
  logic [PERIOD_W-1:0] tone_per_eff [3];
  cnt_res_t            tone_res [3];
  logic [PERIOD_W-1:0] tone_cnt_next [3];
  logic [2:0]          tone_bit_next;
  logic [2:0]          tone_out;
  logic [PERIOD_W-1:0] noise_per_eff;
  cnt_res_t            noise_res;
  logic [NOISE_W-1:0]  noise_mid;
  logic [NOISE_W-1:0]  noise_shift_next;
  logic                noise_out;
  logic [PERIOD_W-1:0] env_per_eff;
  cnt_res_t            env_res;
  env_t                env_mid;
  env_t                env_st_next;
  logic [PERIOD_W-1:0] env_cnt_next;
  logic                env_moving;
  logic                env_moving_mid;
  logic [2:0]          gate_next;
  logic [LEVEL_W-1:0]  level_next [3];

  // Handshake
  assign out_free   = !out_valid || out_ready;
  assign s1_tick    = s1_valid && (s1_func == FUNC_TICK);
  assign s1_restart = s1_valid && (s1_func == FUNC_RESTART);
  assign s1_adv     = s1_valid && ((s1_func == FUNC_RESTART) || out_free);
  assign in_ready   = !s1_valid || s1_adv;

  // Capture configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_period[0]  <= '0;
      tone_period[1]  <= '0;
      tone_period[2]  <= '0;
      noise_period    <= '0;
      envelope_period <= '0;
      mixer_enables   <= MIXER_RESET;
      fixed_levels    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TONE_A:   tone_period[0]  <= cfg_data;
        REG_TONE_B:   tone_period[1]  <= cfg_data;
        REG_TONE_C:   tone_period[2]  <= cfg_data;
        REG_NOISE:    noise_period    <= cfg_data;
        REG_ENVELOPE: envelope_period <= cfg_data;
        REG_MIXER:    mixer_enables   <= cfg_data[8:0];
        REG_FIXED:    fixed_levels    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Hold the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func  <= func;
      s1_shape <= envelope_shape;
    end
  end

  // Tone counters
  for (genvar k = 0; k < 3; k++) begin : g_tone
    assign tone_per_eff[k] = (tone_period[k] == '0) ? PERIOD_W'(1) : tone_period[k];

    psg_cnt u_cnt (
      .cnt    (tone_cnt[k]),
      .period (tone_per_eff[k]),
      .pre_en (tone_per_eff[k] != PERIOD_W'(1)),
      .res    (tone_res[k])
    );

    assign tone_out[k]      = tone_bit[k] ^ tone_res[k].pre;
    assign tone_bit_next[k] = tone_out[k] ^ tone_res[k].post;
    assign tone_cnt_next[k] = tone_res[k].cnt_run;
  end

  // Noise generator
  assign noise_per_eff = (noise_period < PERIOD_W'(2)) ? PERIOD_W'(2) : noise_period;

  psg_cnt u_noise_cnt (
    .cnt    (noise_cnt),
    .period (noise_per_eff),
    .pre_en (1'b1),
    .res    (noise_res)
  );

  always_comb begin
    noise_mid        = noise_res.pre ? noise_shift_once(noise_shift) : noise_shift;
    noise_out        = noise_mid[0];
    noise_shift_next = noise_res.post ? noise_shift_once(noise_mid) : noise_mid;
  end

  // Envelope generator: up to two steps per tick
  assign env_per_eff = (envelope_period == '0) ? PERIOD_W'(1) : envelope_period;
  assign env_moving  = (env_st.phase == PH_FALL) || (env_st.phase == PH_RISE);

  psg_cnt u_env_cnt (
    .cnt    (env_cnt),
    .period (env_per_eff),
    .pre_en (env_moving),
    .res    (env_res)
  );

  always_comb begin
    env_mid        = env_res.pre ? env_step(env_st, env_kind) : env_st;
    env_moving_mid = (env_mid.phase == PH_FALL) || (env_mid.phase == PH_RISE);
    if (env_moving_mid) begin
      env_cnt_next = env_res.cnt_run;
      env_st_next  = env_res.post ? env_step(env_mid, env_kind) : env_mid;
    end else begin
      env_cnt_next = env_res.cnt_hold;
      env_st_next  = env_mid;
    end
  end

  // Mix each channel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gate_next[k] = !(mixer_enables[3*k] && !tone_out[k]) &&
                     !(mixer_enables[3*k+1] && !noise_out);
      level_next[k] = mixer_enables[3*k+2] ? env_mid.level : fixed_levels[5*k +: 5];
    end
  end

  // Advance generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        tone_cnt[k] <= '0;
      end
      tone_bit    <= '0;
      noise_cnt   <= '0;
      noise_shift <= NOISE_SEED;
      env_cnt     <= '0;
      env_st      <= '{level: '0, phase: PH_STILL};
      env_kind    <= '0;
    end else if (s1_adv) begin
      if (s1_func == FUNC_RESTART) begin
        env_kind <= s1_shape;
        env_cnt  <= '0;
        if (!s1_shape[2]) begin
          env_st <= '{level: LEVEL_MAX, phase: PH_FALL};
        end else begin
          env_st <= '{level: '0, phase: PH_RISE};
        end
      end else begin
        for (int k = 0; k < 3; k++) begin
          tone_cnt[k] <= tone_cnt_next[k];
        end
        tone_bit    <= tone_bit_next;
        noise_cnt   <= noise_res.cnt_run;
        noise_shift <= noise_shift_next;
        env_cnt     <= env_cnt_next;
        env_st      <= env_st_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_tick) begin
      gate_a  <= gate_next[0];
      gate_b  <= gate_next[1];
      gate_c  <= gate_next[2];
      level_a <= level_next[0];
      level_b <= level_next[1];
      level_c <= level_next[2];
    end
  end

`ifndef SYNTHESIS
  a_noise_nonzero: assert property (@(posedge clk) disable iff (rst)
    noise_shift != '0)
    else $error("noise shift register reached zero");

  a_restart_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_restart) |=> (env_cnt == '0) && (env_st.phase != PH_STILL))
    else $error("envelope restart did not start a moving phase");

  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_tick) |=> out_valid)
    else $error("tick word produced no result");
`endif

endmodule

// ----- hdl/psg_cnt.sv -----
module psg_cnt
  import psg_pkg::*;
(
  input  logic [PERIOD_W-1:0] cnt,
  input  logic [PERIOD_W-1:0] period,
  input  logic                pre_en,
  output cnt_res_t            res
);

  logic [PERIOD_W-1:0] cnt_clamp;
  logic [PERIOD_W:0]   cnt_inc;

  // Clamp to a shrunken period, take a step that is already due, then advance the count
  always_comb begin
    cnt_clamp    = (cnt < period) ? cnt : period;
    res.pre      = pre_en && (cnt_clamp == period);
    res.cnt_hold = res.pre ? '0 : cnt_clamp;
    cnt_inc      = {1'b0, res.cnt_hold} + 1'b1;
    res.post     = cnt_inc >= {1'b0, period};
    res.cnt_run  = res.post ? '0 : cnt_inc[PERIOD_W-1:0];
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import psg_pkg::*;

  localparam int unsigned ITEM_TARGET = 1350;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned REPORT_CAP = 30;

  // Envelope shape codes with their own end behaviour; shapes 0-7 are
  // told apart by their top two bits
  localparam logic [3:0] SHAPE_SAW_FALL       = 4'd8;
  localparam logic [3:0] SHAPE_FALL_ONCE      = 4'd9;
  localparam logic [3:0] SHAPE_TRI_FALL       = 4'd10;
  localparam logic [3:0] SHAPE_FALL_HOLD_HIGH = 4'd11;
  localparam logic [3:0] SHAPE_SAW_RISE       = 4'd12;
  localparam logic [3:0] SHAPE_RISE_HOLD      = 4'd13;
  localparam logic [3:0] SHAPE_TRI_RISE       = 4'd14;
  localparam logic [3:0] SHAPE_RISE_ONCE      = 4'd15;
  localparam int unsigned ATTACK_BIT = 2;

  typedef struct packed {
    logic [2:0]      gate;
    logic [2:0][4:0] level;
  } sample_t;

  // Sound generator predictor and queue of samples still to arrive
  class psg_scoreboard;
    int unsigned tone_period[3];
    int unsigned noise_period;
    int unsigned env_period;
    logic [8:0]  mixer;
    logic [14:0] fixed;

    int unsigned tone_cnt[3];
    bit          tone_bit[3];
    int unsigned noise_cnt;
    logic [16:0] noise_sr;
    int unsigned env_cnt;
    logic [4:0]  env_lvl;
    phase_t      env_ph;
    logic [3:0]  env_kind;

    sample_t     pending[$];
    int unsigned errors;
    int unsigned n_ticks;
    int unsigned n_restarts;
    int unsigned n_checked;

    function new();
      int k;
      for (k = 0; k < 3; k++) begin
        tone_period[k] = 0;
        tone_cnt[k] = 0;
        tone_bit[k] = 1'b0;
      end
      noise_period = 0;
      env_period = 0;
      mixer = MIXER_RESET;
      fixed = '0;
      noise_cnt = 0;
      noise_sr = NOISE_SEED;
      env_cnt = 0;
      env_lvl = '0;
      env_ph = PH_STILL;
      env_kind = '0;
      errors = 0;
      n_ticks = 0;
      n_restarts = 0;
      n_checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        REG_TONE_A:   tone_period[0] = v;
        REG_TONE_B:   tone_period[1] = v;
        REG_TONE_C:   tone_period[2] = v;
        REG_NOISE:    noise_period = v;
        REG_ENVELOPE: env_period = v;
        REG_MIXER:    mixer = v[8:0];
        REG_FIXED:    fixed = v[14:0];
        default: ;
      endcase
    endfunction

    // Square wave: sample the bit, then advance the count
    function bit tone_advance(int k);
      int unsigned p, c;
      bit b, o;
      p = (tone_period[k] < 1) ? 1 : tone_period[k];
      c = (tone_cnt[k] < p) ? tone_cnt[k] : p;
      b = tone_bit[k];
      if (p == 1) begin
        o = b;
        b = !b;
        c = 0;
      end else begin
        // a count left at the period by a shrink is a toggle already due
        if (c == p) begin
          b = !b;
          c = 0;
        end
        o = b;
        c++;
        if (c >= p) begin
          b = !b;
          c = 0;
        end
      end
      tone_cnt[k] = c;
      tone_bit[k] = b;
      return o;
    endfunction

    function logic [16:0] lfsr_next(logic [16:0] s);
      return {1'b0, s[16:1]} ^ (s[0] ? NOISE_TAPS : 17'd0);
    endfunction

    function bit noise_advance();
      int unsigned p, c;
      bit o;
      p = (noise_period < 2) ? 2 : noise_period;
      c = (noise_cnt < p) ? noise_cnt : p;
      if (c == p) begin
        noise_sr = lfsr_next(noise_sr);
        c = 0;
      end
      o = noise_sr[0];
      c++;
      if (c >= p) begin
        noise_sr = lfsr_next(noise_sr);
        c = 0;
      end
      noise_cnt = c;
      return o;
    endfunction

    // One level step; at either end the shape decides what follows
    function void env_level_step();
      if (env_ph == PH_FALL) begin
        if (env_lvl != 5'd0) begin
          env_lvl = env_lvl - 1'b1;
        end else if (env_kind[3:2] == 2'b00 || env_kind == SHAPE_FALL_ONCE) begin
          env_ph = PH_STILL;
        end else if (env_kind == SHAPE_SAW_FALL) begin
          env_lvl = LEVEL_MAX;
        end else if (env_kind == SHAPE_TRI_FALL || env_kind == SHAPE_TRI_RISE) begin
          env_ph = PH_RISE;
        end else if (env_kind == SHAPE_FALL_HOLD_HIGH) begin
          env_lvl = LEVEL_MAX;
          env_ph = PH_STILL;
        end
      end else if (env_ph == PH_RISE) begin
        if (env_lvl != LEVEL_MAX) begin
          env_lvl = env_lvl + 1'b1;
        end else if (env_kind[3:2] == 2'b01 || env_kind == SHAPE_RISE_ONCE) begin
          env_lvl = 5'd0;
          env_ph = PH_STILL;
        end else if (env_kind == SHAPE_TRI_FALL || env_kind == SHAPE_TRI_RISE) begin
          env_ph = PH_FALL;
        end else if (env_kind == SHAPE_SAW_RISE) begin
          env_lvl = 5'd0;
        end else if (env_kind == SHAPE_RISE_HOLD) begin
          env_ph = PH_STILL;
        end
      end
    endfunction

    function logic [4:0] env_advance();
      int unsigned p, c;
      logic [4:0] o;
      p = (env_period < 1) ? 1 : env_period;
      c = (env_cnt < p) ? env_cnt : p;
      if ((env_ph == PH_FALL || env_ph == PH_RISE) && c == p) begin
        c = 0;
        env_level_step();
      end
      o = env_lvl;
      // hold the count while still
      if (env_ph == PH_FALL || env_ph == PH_RISE) begin
        c++;
        if (c >= p) begin
          c = 0;
          env_level_step();
        end
      end
      env_cnt = c;
      return o;
    endfunction

    function sample_t predict_tick();
      sample_t s;
      bit nbit, tbit;
      logic [4:0] elev;
      logic [2:0] opts;
      int k;
      nbit = noise_advance();
      elev = env_advance();
      for (k = 0; k < 3; k++) begin
        tbit = tone_advance(k);
        opts = mixer[3*k +: 3];
        s.gate[k] = !((opts[0] && !tbit) || (opts[1] && !nbit));
        s.level[k] = opts[2] ? elev : fixed[5*k +: 5];
      end
      return s;
    endfunction

    function void note_word(logic f, logic [3:0] shape);
      if (f == FUNC_RESTART) begin
        env_kind = shape;
        env_cnt = 0;
        if (shape[ATTACK_BIT]) begin
          env_lvl = 5'd0;
          env_ph = PH_RISE;
        end else begin
          env_lvl = LEVEL_MAX;
          env_ph = PH_FALL;
        end
        n_restarts++;
      end else begin
        pending.push_back(predict_tick());
        n_ticks++;
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= REPORT_CAP) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_word(logic [2:0] gate, logic [2:0][4:0] level);
      sample_t want;
      string ch[3];
      int k;
      ch = '{"a", "b", "c"};
      if (pending.size() == 0) begin
        report_mismatch("sample word with no tick waiting");
      end else begin
        want = pending.pop_front();
        n_checked++;
        for (k = 0; k < 3; k++) begin
          if (gate[k] !== want.gate[k])
            report_mismatch($sformatf("gate_%s got %b want %b", ch[k], gate[k], want.gate[k]));
          if (level[k] !== want.level[k])
            report_mismatch($sformatf("level_%s got %0d want %0d", ch[k], level[k],
                                      want.level[k]));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = FUNC_TICK;
  logic [3:0] envelope_shape = 4'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic gate_a, gate_b, gate_c;
  logic [LEVEL_W-1:0] level_a, level_b, level_c;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_TONE_A;
  logic [PERIOD_W-1:0] cfg_data = '0;

  psg_scoreboard sb = new();
  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 78;
  int unsigned items_sent = 0;
  int unsigned n_settings = 0;
  int unsigned quiet_cycles = 0;

  psg_tone_noise_envelope_synth_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .envelope_shape(envelope_shape),
    .out_valid(out_valid), .out_ready(out_ready),
    .gate_a(gate_a), .gate_b(gate_b), .gate_c(gate_c),
    .level_a(level_a), .level_b(level_b), .level_c(level_c),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Stall the sample side at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Note accepted words and check accepted samples
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(func, envelope_shape);
      if (out_valid && out_ready)
        sb.check_word({gate_c, gate_b, gate_a}, {level_c, level_b, level_a});
    end
  end

  // Give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_word(input logic f, input logic [3:0] shape);
    // receiver quiet first, then sender, then neither
    if (items_sent < ITEM_TARGET / 3) begin
      send_idle_pct = 11;
      recv_idle_pct = 78;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 78;
      recv_idle_pct = 11;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    envelope_shape <= shape;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every sample is back and restarts are through
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_setting(input logic [15:0] pa, pb, pc, np, ep, mx, fx);
    write_reg(REG_TONE_A, pa);
    write_reg(REG_TONE_B, pb);
    write_reg(REG_TONE_C, pc);
    write_reg(REG_NOISE, np);
    write_reg(REG_ENVELOPE, ep);
    write_reg(REG_MIXER, mx);
    write_reg(REG_FIXED, fx);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Mostly short periods so edges come often, now and then a long one
  function automatic logic [15:0] pick_period();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 16'($urandom_range(3));
    if (r < 85) return 16'($urandom_range(40, 4));
    return 16'($urandom);
  endfunction

  // Short envelope periods so sweeps reach their ends within a phase
  function automatic logic [15:0] pick_env_period();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom_range(2));
    if (r < 85) return 16'($urandom_range(8, 3));
    return 16'($urandom);
  endfunction

  // A restart, then a run of ticks with the odd restart thrown in
  task automatic run_phase(input int unsigned n);
    int unsigned i;
    send_word(FUNC_RESTART, 4'($urandom_range(15)));
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) send_word(FUNC_RESTART, 4'($urandom_range(15)));
      else send_word(FUNC_TICK, 4'($urandom_range(15)));
    end
  endtask

  initial begin
    int s;
    int unsigned ph;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a couple of ticks, then every shape once
    send_word(FUNC_TICK, 4'd0);
    send_word(FUNC_TICK, 4'd15);
    for (s = 0; s < 16; s++) begin
      send_word(FUNC_RESTART, 4'(s));
      if (s % 2 == 1) send_word(FUNC_TICK, 4'($urandom_range(15)));
    end
    settle();

    ph = 0;
    while (items_sent < ITEM_TARGET) begin
      case (ph)
        // shortest periods, every source and envelope on every channel
        0: apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h01FF, 16'h7FFF);
        // longest periods, all gates open, fixed levels of zero
        1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        // long counts left behind get clamped to the new period
        2: apply_setting(16'd12, 16'd12, 16'd12, 16'd12, 16'd12,
                         16'($urandom), 16'($urandom));
        // shrink onto a count that sits right at the new period
        3: apply_setting(16'd6, 16'd6, 16'd6, 16'd6, 16'd6,
                         16'($urandom), 16'($urandom));
        default: apply_setting(pick_period(), pick_period(), pick_period(), pick_period(),
                               pick_env_period(), 16'($urandom), 16'($urandom));
      endcase
      run_phase((ph == 2) ? 30 : $urandom_range(90, 40));
      settle();
      ph++;
    end

    $display("covered %0d ticks and %0d envelope restarts over %0d register settings",
             sb.n_ticks, sb.n_restarts, n_settings);
    $display("compared %0d sample words, %0d field mismatches", sb.n_checked, sb.errors);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/psg_pkg.sv
hdl/psg_cnt.sv
hdl/psg_tone_noise_envelope_synth_core.sv
tb/tb_top.sv
